// ----- rtl/core/pbrq_pkg.sv -----
package pbrq_pkg;

    localparam int THREADS = 64;
    localparam int LEVELS  = 32;
    localparam int TID_W   = $clog2(THREADS);
    localparam int LVL_W   = $clog2(LEVELS);

    localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
    localparam logic [1:0] FUNC_DEQUEUE = 2'd1;
    localparam logic [1:0] FUNC_ELECT   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    localparam logic [1:0] ST_DONE        = 2'd0;
    localparam logic [1:0] ST_RUNNING     = 2'd1;
    localparam logic [1:0] ST_NOT_QUEUED  = 2'd2;
    localparam logic [1:0] ST_ALREADY_QUE = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_DQ_LVL,
        S_DQ_UPD,
        S_EL_HEAD
    } t_state;

    typedef struct packed {
        logic             found;
        logic [LVL_W-1:0] level;
    } t_first;

endpackage

// ----- rtl/core/pbrq_first_set.sv -----
module pbrq_first_set (
    input  logic [pbrq_pkg::LEVELS-1:0] i_bitmap,
    output pbrq_pkg::t_first            o_first
);

    // lowest set bit wins: scan from the top so lower indexes overwrite
    always_comb begin
        o_first = '0;
        for (int i = pbrq_pkg::LEVELS - 1; i >= 0; i--) begin
            if (i_bitmap[i]) begin
                o_first.found = 1'b1;
                o_first.level = pbrq_pkg::LVL_W'(i);
            end
        end
    end

endmodule

// ----- rtl/core/priority_bitmap_run_queue.sv -----
// Ignored operations, enqueue to an empty level and idle elect answer from S_IDLE;
// enqueue to a busy level reads head/tail for S_ENQ; dequeue reads links for
// S_DQ_LVL, head/tail for S_DQ_UPD; elect of a queued thread first reads head/tail
// for S_EL_HEAD. Throughput: one transaction at a time; busy holds until the
// write back, and the receiver cannot stall. Synchronous active-low reset clears
// the bitmap, queued marks and running thread; link memories need no clearing.
module priority_bitmap_run_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_func,
    input  logic [5:0] i_thread_id,
    input  logic [4:0] i_priority_req,
    output logic       o_strobe,
    output logic [1:0] o_status,
    output logic [5:0] o_chosen_thread,
    output logic       o_chosen_idle
);

    localparam int TW = pbrq_pkg::TID_W;
    localparam int LW = pbrq_pkg::LVL_W;

    // Link memories, one entry per thread
    logic [TW-1:0] next_mem [pbrq_pkg::THREADS];
    logic [TW-1:0] prev_mem [pbrq_pkg::THREADS];
    logic [LW-1:0] lvl_mem  [pbrq_pkg::THREADS];
    // Level memory: {head, tail}
    logic [2*TW-1:0] lq_mem [pbrq_pkg::LEVELS];

    pbrq_pkg::t_state r_state, n_state;

    logic [pbrq_pkg::LEVELS-1:0]  r_nonempty;
    logic [pbrq_pkg::THREADS-1:0] r_queued;
    logic [TW-1:0] r_run_thread;
    logic          r_run_valid;
    logic          r_elect;
    logic [TW-1:0] r_t;
    logic [LW-1:0] r_lv;
    logic [TW-1:0] r_p, r_n;

    // registered read data
    logic [TW-1:0]   r_next_rd, r_prev_rd;
    logic [LW-1:0]   r_lvl_rd;
    logic [2*TW-1:0] r_lq_rd;

    pbrq_pkg::t_first first;

    // control from the output decoder
    logic [TW-1:0] thr_raddr;
    logic [LW-1:0] lq_raddr;
    logic          accept;
    logic          imm_done;
    logic [1:0]    imm_status;

    logic [TW-1:0] rd_head, rd_tail;
    logic          is_head, is_tail;

    pbrq_first_set u_first (
        .i_bitmap (r_nonempty),
        .o_first  (first)
    );

    assign busy    = (r_state != pbrq_pkg::S_IDLE);
    assign accept  = start && !busy;
    assign rd_head = r_lq_rd[2*TW-1:TW];
    assign rd_tail = r_lq_rd[TW-1:0];
    assign is_head = (rd_head == r_t);
    assign is_tail = (rd_tail == r_t);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pbrq_pkg::S_IDLE: begin
                if (accept) begin
                    priority if (i_func == pbrq_pkg::FUNC_ENQUEUE) begin
                        if (!r_queued[i_thread_id] && r_nonempty[i_priority_req])
                            n_state = pbrq_pkg::S_ENQ;
                    end else if (i_func == pbrq_pkg::FUNC_DEQUEUE) begin
                        if (!(r_run_valid && r_run_thread == i_thread_id)
                                && r_queued[i_thread_id])
                            n_state = pbrq_pkg::S_DQ_LVL;
                    end else if (i_func == pbrq_pkg::FUNC_ELECT) begin
                        if (first.found)
                            n_state = pbrq_pkg::S_EL_HEAD;
                    end
                end
            end
            pbrq_pkg::S_ENQ:     n_state = pbrq_pkg::S_IDLE;
            pbrq_pkg::S_EL_HEAD: n_state = pbrq_pkg::S_DQ_LVL;
            pbrq_pkg::S_DQ_LVL:  n_state = pbrq_pkg::S_DQ_UPD;
            pbrq_pkg::S_DQ_UPD:  n_state = pbrq_pkg::S_IDLE;
            default:             n_state = pbrq_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: read addresses and immediate answers
    always_comb begin
        thr_raddr  = i_thread_id;
        lq_raddr   = i_priority_req;
        imm_done   = 1'b0;
        imm_status = pbrq_pkg::ST_DONE;
        unique case (r_state)
            pbrq_pkg::S_IDLE: begin
                if (i_func == pbrq_pkg::FUNC_ELECT)
                    lq_raddr = first.level;
                if (accept) begin
                    priority if (i_func == pbrq_pkg::FUNC_ENQUEUE) begin
                        if (r_queued[i_thread_id]) begin
                            imm_done   = 1'b1;
                            imm_status = pbrq_pkg::ST_ALREADY_QUE;
                        end else if (!r_nonempty[i_priority_req]) begin
                            imm_done = 1'b1;
                        end
                    end else if (i_func == pbrq_pkg::FUNC_DEQUEUE) begin
                        if (r_run_valid && r_run_thread == i_thread_id) begin
                            imm_done   = 1'b1;
                            imm_status = pbrq_pkg::ST_RUNNING;
                        end else if (!r_queued[i_thread_id]) begin
                            imm_done   = 1'b1;
                            imm_status = pbrq_pkg::ST_NOT_QUEUED;
                        end
                    end else if (i_func == pbrq_pkg::FUNC_ELECT) begin
                        if (!first.found)
                            imm_done = 1'b1;
                    end else begin
                        imm_done = 1'b1;
                    end
                end
            end
            pbrq_pkg::S_EL_HEAD: thr_raddr = rd_head;
            pbrq_pkg::S_DQ_LVL:  lq_raddr  = r_lvl_rd;
            pbrq_pkg::S_ENQ, pbrq_pkg::S_DQ_UPD: begin
            end
            default: begin
            end
        endcase
    end

    // Memory reads, registered
    always_ff @(posedge i_clk) begin
        r_next_rd <= next_mem[thr_raddr];
        r_prev_rd <= prev_mem[thr_raddr];
        r_lvl_rd  <= lvl_mem[thr_raddr];
        r_lq_rd   <= lq_mem[lq_raddr];
    end

    // Memory writes
    always_ff @(posedge i_clk) begin
        if (r_state == pbrq_pkg::S_IDLE && accept && i_func == pbrq_pkg::FUNC_ENQUEUE
                && !r_queued[i_thread_id] && !r_nonempty[i_priority_req]) begin
            lq_mem[i_priority_req]  <= {i_thread_id, i_thread_id};
            lvl_mem[i_thread_id]    <= i_priority_req;
        end
        if (r_state == pbrq_pkg::S_ENQ) begin
            next_mem[rd_tail] <= r_t;
            prev_mem[r_t]     <= rd_tail;
            lvl_mem[r_t]      <= r_lv;
            lq_mem[r_lv]      <= {rd_head, r_t};
        end
        if (r_state == pbrq_pkg::S_DQ_UPD && !(is_head && is_tail)) begin
            lq_mem[r_lv] <= {(is_head ? r_n : rd_head), (is_tail ? r_p : rd_tail)};
            if (!is_head)
                next_mem[r_p] <= r_n;
            if (!is_tail)
                prev_mem[r_n] <= r_p;
        end
    end

    // Transaction registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_t     <= i_thread_id;
            r_lv    <= i_priority_req;
            r_elect <= (i_func == pbrq_pkg::FUNC_ELECT);
        end
        if (r_state == pbrq_pkg::S_EL_HEAD)
            r_t <= rd_head;
        if (r_state == pbrq_pkg::S_DQ_LVL) begin
            r_p  <= r_prev_rd;
            r_n  <= r_next_rd;
            r_lv <= r_lvl_rd;
        end
    end

    // Control state and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= pbrq_pkg::S_IDLE;
            r_nonempty      <= '0;
            r_queued        <= '0;
            r_run_thread    <= '0;
            r_run_valid     <= 1'b0;
            o_strobe        <= 1'b0;
            o_status        <= pbrq_pkg::ST_DONE;
            o_chosen_thread <= '0;
            o_chosen_idle   <= 1'b0;
        end else begin
            r_state         <= n_state;
            o_strobe        <= 1'b0;
            o_status        <= pbrq_pkg::ST_DONE;
            o_chosen_thread <= '0;
            o_chosen_idle   <= 1'b0;
            if (imm_done) begin
                o_strobe <= 1'b1;
                o_status <= imm_status;
                if (i_func == pbrq_pkg::FUNC_ELECT) begin
                    o_chosen_idle <= 1'b1;
                    r_run_valid   <= 1'b0;
                    r_run_thread  <= '0;
                end
                if (i_func == pbrq_pkg::FUNC_ENQUEUE && imm_status == pbrq_pkg::ST_DONE) begin
                    r_queued[i_thread_id]      <= 1'b1;
                    r_nonempty[i_priority_req] <= 1'b1;
                end
            end
            if (r_state == pbrq_pkg::S_ENQ) begin
                r_queued[r_t] <= 1'b1;
                o_strobe      <= 1'b1;
            end
            if (r_state == pbrq_pkg::S_DQ_UPD) begin
                // unlink: drop the level bit when the thread was alone there
                if (is_head && is_tail)
                    r_nonempty[r_lv] <= 1'b0;
                r_queued[r_t] <= 1'b0;
                o_strobe      <= 1'b1;
                if (r_elect) begin
                    o_chosen_thread <= r_t;
                    r_run_thread    <= r_t;
                    r_run_valid     <= 1'b1;
                end
            end
        end
    end

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_chosen_idle |-> o_chosen_thread == '0)
        else $error("idle election carries a thread id");

    a_idle_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_chosen_idle |-> !r_run_valid)
        else $error("running thread kept after idle election");

    a_enq_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pbrq_pkg::S_ENQ |=> r_queued[$past(r_t)] && r_nonempty[$past(r_lv)])
        else $error("enqueue left thread unmarked");

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && busy |-> r_state != pbrq_pkg::S_IDLE && !$past(accept))
        else $error("strobe while a fresh transaction is in flight");

endmodule

// ----- tb/priority_bitmap_run_queue_tb.sv -----
module priority_bitmap_run_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_func;
    logic [5:0] i_thread_id;
    logic [4:0] i_priority_req;
    logic       o_strobe;
    logic [1:0] o_status;
    logic [5:0] o_chosen_thread;
    logic       o_chosen_idle;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] chosen;
        logic       idle;
    } t_outcome;

    // Shadow copy of the scheduler state.
    logic [pbrq_pkg::LEVELS-1:0]  sh_nonempty;
    logic [5:0]                   sh_head [pbrq_pkg::LEVELS];
    logic [5:0]                   sh_tail [pbrq_pkg::LEVELS];
    logic [5:0]                   sh_next [pbrq_pkg::THREADS];
    logic [5:0]                   sh_prev [pbrq_pkg::THREADS];
    logic [4:0]                   sh_level [pbrq_pkg::THREADS];
    logic [pbrq_pkg::THREADS-1:0] sh_queued;
    logic [5:0]                   sh_run_tid;
    logic                         sh_run_valid;

    t_outcome outcome_q[$];
    bit       failed;
    int       quiet_cycles;
    int       idle_pct;

    priority_bitmap_run_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_thread_id     (i_thread_id),
        .i_priority_req  (i_priority_req),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_chosen_thread (o_chosen_thread),
        .o_chosen_idle   (o_chosen_idle)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Remove a queued thread from its level's list.
    function automatic void unlink_tid(input logic [5:0] t);
        logic [4:0] lv;
        logic       is_head;
        logic       is_tail;
        lv = sh_level[t];
        is_head = (sh_head[lv] == t);
        is_tail = (sh_tail[lv] == t);
        if (is_head && is_tail) begin
            sh_nonempty[lv] = 1'b0;
        end else begin
            if (is_head) sh_head[lv] = sh_next[t];
            else sh_next[sh_prev[t]] = sh_next[t];
            if (is_tail) sh_tail[lv] = sh_prev[t];
            else sh_prev[sh_next[t]] = sh_prev[t];
        end
        sh_queued[t] = 1'b0;
    endfunction

    // Advance the shadow state by one transaction and return its outcome.
    function automatic t_outcome schedule_op(input logic [1:0] fn, input logic [5:0] t,
                                             input logic [4:0] lv);
        t_outcome r;
        int       best;
        r = '0;
        case (fn)
            pbrq_pkg::FUNC_ENQUEUE: begin
                if (sh_queued[t]) begin
                    r.status = pbrq_pkg::ST_ALREADY_QUE;
                end else begin
                    if (sh_nonempty[lv]) begin
                        sh_next[sh_tail[lv]] = t;
                        sh_prev[t] = sh_tail[lv];
                    end else begin
                        sh_head[lv] = t;
                        sh_nonempty[lv] = 1'b1;
                    end
                    sh_tail[lv] = t;
                    sh_level[t] = lv;
                    sh_queued[t] = 1'b1;
                end
            end
            pbrq_pkg::FUNC_DEQUEUE: begin
                if (sh_run_valid && sh_run_tid == t) r.status = pbrq_pkg::ST_RUNNING;
                else if (!sh_queued[t]) r.status = pbrq_pkg::ST_NOT_QUEUED;
                else unlink_tid(t);
            end
            pbrq_pkg::FUNC_ELECT: begin
                best = pbrq_pkg::LEVELS;
                for (int i = pbrq_pkg::LEVELS - 1; i >= 0; i--) begin
                    if (sh_nonempty[i]) best = i;
                end
                if (best == pbrq_pkg::LEVELS) begin
                    r.idle = 1'b1;
                    sh_run_valid = 1'b0;
                    sh_run_tid = '0;
                end else begin
                    r.chosen = sh_head[best];
                    unlink_tid(r.chosen);
                    sh_run_tid = r.chosen;
                    sh_run_valid = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Send one transaction: hold start until it is taken.
    task automatic send_op(input logic [1:0] fn, input logic [5:0] t, input logic [4:0] lv);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= fn;
        i_thread_id <= t;
        i_priority_req <= lv;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        outcome_q.push_back(schedule_op(fn, t, lv));
    endtask

    // Check each strobed result against the oldest prediction.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_strobe) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d thread=%0d idle=%0d",
                         $time, o_status, o_chosen_thread, o_chosen_idle);
                failed = 1'b1;
            end else begin
                want = outcome_q.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    failed = 1'b1;
                end
                if (o_chosen_thread !== want.chosen) begin
                    $display("%0t: chosen_thread expected %0d actual %0d",
                             $time, want.chosen, o_chosen_thread);
                    failed = 1'b1;
                end
                if (o_chosen_idle !== want.idle) begin
                    $display("%0t: chosen_idle expected %0d actual %0d",
                             $time, want.idle, o_chosen_idle);
                    failed = 1'b1;
                end
            end
        end
    end

    // Drop the run when neither side moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[priority_bitmap_run_queue] ERROR");
            $finish;
        end
    end

    // Cover the extremes, every func, and the ignored cases.
    task automatic test_directed();
        send_op(pbrq_pkg::FUNC_ELECT, 6'd0, 5'd0);      // idle elect
        send_op(pbrq_pkg::FUNC_DEQUEUE, 6'd0, 5'd0);    // not queued, idle running
        send_op(pbrq_pkg::FUNC_ENQUEUE, 6'd63, 5'd31);
        send_op(pbrq_pkg::FUNC_ENQUEUE, 6'd0, 5'd31);
        send_op(pbrq_pkg::FUNC_ENQUEUE, 6'd42, 5'd31);
        send_op(pbrq_pkg::FUNC_ENQUEUE, 6'd21, 5'd0);
        send_op(pbrq_pkg::FUNC_ENQUEUE, 6'd63, 5'd5);   // already queued
        send_op(pbrq_pkg::FUNC_DEQUEUE, 6'd0, 5'd0);    // middle of a list
        send_op(pbrq_pkg::FUNC_ELECT, 6'd63, 5'd31);    // takes level 0
        send_op(pbrq_pkg::FUNC_DEQUEUE, 6'd21, 5'd0);   // running thread
        send_op(pbrq_pkg::FUNC_ENQUEUE, 6'd21, 5'd10);  // running thread may join
        send_op(pbrq_pkg::FUNC_DEQUEUE, 6'd21, 5'd0);   // still the running one
        send_op(pbrq_pkg::FUNC_UNUSED, 6'd63, 5'd31);   // unused func
        send_op(pbrq_pkg::FUNC_ELECT, 6'd0, 5'd0);
        send_op(pbrq_pkg::FUNC_ELECT, 6'd0, 5'd0);
        send_op(pbrq_pkg::FUNC_DEQUEUE, 6'd42, 5'd0);   // last entry of its level
        send_op(pbrq_pkg::FUNC_ELECT, 6'd0, 5'd0);
        send_op(pbrq_pkg::FUNC_ELECT, 6'd0, 5'd0);      // empty again
    endtask

    // Random mix weighted so the queues fill and drain repeatedly.
    task automatic test_random(input int count, input int pct);
        int         sel;
        logic [1:0] fn;
        idle_pct = pct;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 45) fn = pbrq_pkg::FUNC_ENQUEUE;
            else if (sel < 70) fn = pbrq_pkg::FUNC_DEQUEUE;
            else if (sel < 97) fn = pbrq_pkg::FUNC_ELECT;
            else fn = pbrq_pkg::FUNC_UNUSED;
            send_op(fn, 6'($urandom_range(63)),
                    ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(3)));
        end
    endtask

    initial begin
        failed = 1'b0;
        idle_pct = 26;
        start <= 1'b0;
        i_func <= '0;
        i_thread_id <= '0;
        i_priority_req <= '0;
        i_rst_n <= 1'b0;
        sh_nonempty = '0;
        sh_queued = '0;
        sh_run_tid = '0;
        sh_run_valid = 1'b0;
        for (int i = 0; i < pbrq_pkg::THREADS; i++) begin
            sh_next[i] = '0;
            sh_prev[i] = '0;
            sh_level[i] = '0;
        end
        for (int i = 0; i < pbrq_pkg::LEVELS; i++) begin
            sh_head[i] = '0;
            sh_tail[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(300, 26);
        test_random(150, 0);   // back-to-back stretch
        test_random(300, 26);
        start <= 1'b0;

        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (!failed) begin
            $display("[priority_bitmap_run_queue] OK");
        end else begin
            $display("[priority_bitmap_run_queue] ERROR");
        end
        $finish;
    end

endmodule
